### rtl/bcsl_pkg.sv
// shared constants, types and helpers for the substring locator
package bcsl_pkg;

  localparam int TARGET_MAX = 16;
  localparam int COORD_BITS = 16;
  localparam int CENTRE_W   = 18;
  localparam int TGT_BYTES  = 16;
  localparam int TIDX_W     = 4;
  localparam int SEEN_W     = $clog2(TARGET_MAX + 1);
  localparam int LEN_W      = 5;
  localparam int CFG_W      = 64;
  localparam int CONF_W     = 16;

  typedef enum logic [1:0] {
    KIND_CHAR   = 2'd0,
    KIND_REGION = 2'd1,
    KIND_LIST   = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    CFG_TGT_FIRST  = 2'd0,
    CFG_TGT_SECOND = 2'd1,
    CFG_TGT_LEN    = 2'd2,
    CFG_UNUSED     = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic shift;
    logic clr;
  } win_ctrl_t;

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    if (c >= 8'h41 && c <= 8'h5A) begin
      return c + 8'h20;
    end
    return c;
  endfunction

endpackage

### rtl/bcsl_cell.sv
// one window byte: holds a character, passes it on and compares it with its target byte
module bcsl_cell
  import bcsl_pkg::*;
(
  input  logic       clk,
  input  logic       shift_en,
  input  logic [7:0] byte_in,
  input  logic [7:0] tgt_byte,
  input  logic       active,
  output logic [7:0] byte_out,
  output logic       hit
);

  logic [7:0] byte_r;
  logic [7:0] byte_nxt;

  always_comb begin
    byte_nxt = shift_en ? byte_in : byte_r;
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
  end

  assign byte_out = byte_r;
  assign hit      = !active || (byte_r == fold_case(tgt_byte));

endmodule

### rtl/bcsl_window.sv
// character window built from a chain of compare cells, with count and sticky match flag
module bcsl_window
  import bcsl_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst_n,
  input  win_ctrl_t                     ctrl,
  input  logic [7:0]                    text_char,
  input  logic [TGT_BYTES*8-1:0]        tgt_bytes,
  input  logic [LEN_W-1:0]              tgt_len,
  output logic                          hit
);

  logic [7:0]            chain [TARGET_MAX+1];
  logic [TARGET_MAX-1:0] cell_hit;
  logic [SEEN_W-1:0]     seen_r;
  logic [SEEN_W-1:0]     seen_nxt;
  logic                  pend_r;
  logic                  pend_nxt;
  logic                  flag_r;
  logic                  flag_nxt;
  logic                  len_ok;
  logic                  seen_ok;
  logic                  match_now;
  logic                  empty;

  assign chain[0] = fold_case(text_char);

  for (genvar j = 0; j < TARGET_MAX; j++) begin : g_cell
    logic [LEN_W-1:0]  rpos;
    logic [TIDX_W-1:0] tidx;
    logic [7:0]        tbyte;
    logic              act;

    always_comb begin
      rpos  = tgt_len - LEN_W'(j) - LEN_W'(1);
      tidx  = rpos[TIDX_W-1:0];
      tbyte = tgt_bytes[tidx*8 +: 8];
      act   = (tgt_len > LEN_W'(j));
    end

    bcsl_cell u_cell (
      .clk      (clk),
      .shift_en (ctrl.shift),
      .byte_in  (chain[j]),
      .tgt_byte (tbyte),
      .active   (act),
      .byte_out (chain[j+1]),
      .hit      (cell_hit[j])
    );
  end

  always_comb begin
    empty     = (tgt_len == '0);
    len_ok    = (tgt_len <= LEN_W'(TARGET_MAX));
    seen_ok   = (LEN_W'(seen_r) >= tgt_len);
    match_now = len_ok && seen_ok && (&cell_hit);
    hit       = empty || flag_r || (pend_r && match_now);
  end

  always_comb begin
    seen_nxt = seen_r;
    pend_nxt = 1'b0;
    flag_nxt = flag_r || (pend_r && match_now);
    if (ctrl.clr) begin
      seen_nxt = '0;
      flag_nxt = 1'b0;
    end else if (ctrl.shift) begin
      pend_nxt = 1'b1;
      if (seen_r < SEEN_W'(TARGET_MAX)) begin
        seen_nxt = seen_r + SEEN_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= '0;
      pend_r <= 1'b0;
      flag_r <= 1'b0;
    end else begin
      seen_r <= seen_nxt;
      pend_r <= pend_nxt;
      flag_r <= flag_nxt;
    end
  end

endmodule

### rtl/best_confidence_substring_locator_unit.sv
// top level: tracks the best-confidence region whose text holds the target, reports its doubled centre
// Takes one word per cycle while not stalled: a text character shifts into a chain of sixteen
// compare cells, and the match of the newest characters against the case-folded target is
// resolved in the following cycle, in time for a region end arriving right behind it. A list end
// loads the result register, so its word appears in the cycle after acceptance; the input stalls
// only while that register is full and the downstream side is stalling. Configuration writes
// take effect at the next clock edge.
module best_confidence_substring_locator_unit
  import bcsl_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wen,
  input  logic [1:0]          cfg_index,
  input  logic [CFG_W-1:0]    cfg_wdata,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          in_kind,
  input  logic [7:0]          in_text_char,
  input  logic [15:0]         in_box_left,
  input  logic [15:0]         in_box_top,
  input  logic [15:0]         in_box_width,
  input  logic [15:0]         in_box_height,
  input  logic [CONF_W-1:0]   in_region_confidence,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_found,
  output logic [CENTRE_W-1:0] out_centre_x_doubled,
  output logic [CENTRE_W-1:0] out_centre_y_doubled
);

  logic [CFG_W-1:0]    tgt_lo_r;
  logic [CFG_W-1:0]    tgt_hi_r;
  logic [LEN_W-1:0]    tgt_len_r;
  logic [CONF_W-1:0]   best_conf_r;
  logic [CONF_W-1:0]   best_conf_nxt;
  logic [CENTRE_W-1:0] best_x_r;
  logic [CENTRE_W-1:0] best_x_nxt;
  logic [CENTRE_W-1:0] best_y_r;
  logic [CENTRE_W-1:0] best_y_nxt;
  logic                any_r;
  logic                any_nxt;
  logic                out_valid_r;
  logic                out_valid_nxt;
  logic                out_found_r;
  logic                out_found_nxt;
  logic [CENTRE_W-1:0] out_x_r;
  logic [CENTRE_W-1:0] out_x_nxt;
  logic [CENTRE_W-1:0] out_y_r;
  logic [CENTRE_W-1:0] out_y_nxt;
  logic                acc;
  logic                is_char;
  logic                is_region;
  logic                is_list;
  logic                win_hit;
  logic [CENTRE_W-1:0] cx;
  logic [CENTRE_W-1:0] cy;
  kind_t               kind;
  win_ctrl_t           wctrl;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tgt_lo_r  <= '0;
      tgt_hi_r  <= '0;
      tgt_len_r <= '0;
    end else if (cfg_wen) begin
      case (cfg_idx_t'(cfg_index))
        CFG_TGT_FIRST:  tgt_lo_r  <= cfg_wdata;
        CFG_TGT_SECOND: tgt_hi_r  <= cfg_wdata;
        CFG_TGT_LEN:    tgt_len_r <= cfg_wdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // input decode
  always_comb begin
    in_stall  = out_valid_r && out_stall;
    acc       = in_valid && !in_stall;
    kind      = kind_t'(in_kind);
    is_char   = acc && (kind == KIND_CHAR);
    is_region = acc && (kind == KIND_REGION);
    is_list   = acc && (kind == KIND_LIST);
    wctrl.shift = is_char;
    wctrl.clr   = is_region || is_list;
  end

  bcsl_window u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (wctrl),
    .text_char (in_text_char),
    .tgt_bytes ({tgt_hi_r, tgt_lo_r}),
    .tgt_len   (tgt_len_r),
    .hit       (win_hit)
  );

  // doubled centre of the incoming box
  always_comb begin
    cx = (CENTRE_W'(in_box_left[COORD_BITS-1:0]) << 1) + CENTRE_W'(in_box_width[COORD_BITS-1:0]);
    cy = (CENTRE_W'(in_box_top[COORD_BITS-1:0]) << 1) + CENTRE_W'(in_box_height[COORD_BITS-1:0]);
  end

  // best region tracking
  always_comb begin
    best_conf_nxt = best_conf_r;
    best_x_nxt    = best_x_r;
    best_y_nxt    = best_y_r;
    any_nxt       = any_r;
    if (is_list) begin
      best_conf_nxt = '0;
      best_x_nxt    = '0;
      best_y_nxt    = '0;
      any_nxt       = 1'b0;
    end else if (is_region && win_hit && (in_region_confidence > best_conf_r)) begin
      best_conf_nxt = in_region_confidence;
      best_x_nxt    = cx;
      best_y_nxt    = cy;
      any_nxt       = 1'b1;
    end
  end

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    out_found_nxt = out_found_r;
    out_x_nxt     = out_x_r;
    out_y_nxt     = out_y_r;
    if (is_list) begin
      out_valid_nxt = 1'b1;
      out_found_nxt = any_r;
      out_x_nxt     = any_r ? best_x_r : '0;
      out_y_nxt     = any_r ? best_y_r : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_conf_r <= '0;
      best_x_r    <= '0;
      best_y_r    <= '0;
      any_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      best_conf_r <= best_conf_nxt;
      best_x_r    <= best_x_nxt;
      best_y_r    <= best_y_nxt;
      any_r       <= any_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_found_r <= out_found_nxt;
    out_x_r     <= out_x_nxt;
    out_y_r     <= out_y_nxt;
  end

  assign out_valid            = out_valid_r;
  assign out_found            = out_found_r;
  assign out_centre_x_doubled = out_x_r;
  assign out_centre_y_doubled = out_y_r;

  a_out_from_list_end: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(in_valid && !in_stall && in_kind == KIND_LIST))
    else $error("result word without a list end");

  a_list_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    is_list |=> (!any_r && best_conf_r == '0))
    else $error("search state not cleared after list end");

  a_idle_best_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !any_r |-> (best_conf_r == '0 && best_x_r == '0 && best_y_r == '0))
    else $error("best region held without a match");

  a_found_has_conf: assert property (@(posedge clk) disable iff (!rst_n)
    any_r |-> best_conf_r != '0)
    else $error("match stored with zero confidence");

endmodule
